/* design/interval_set_table_defines.svh */
// ---------------------------------------------------------------------------
// Interval set table assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef INTERVAL_SET_TABLE_DEFINES_SVH
`define INTERVAL_SET_TABLE_DEFINES_SVH

// Same-cycle implication.
`define IST_ASSERT_HOLD(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval_set_table check failed");

// Next-cycle implication.
`define IST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval_set_table check failed");

`endif

/* design/ist_pkg.sv */
// ---------------------------------------------------------------------------
// ist_pkg
// Types and codes shared by the interval set table modules.
// ---------------------------------------------------------------------------
package ist_pkg;

  // Command codes.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One stored interval [lo, hi), both signed two's complement.
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } entry_t;

  // Signed compares of one stored entry against the working interval.
  typedef struct packed {
    logic hi_lt_start;
    logic end_lt_lo;
    logic start_lt_lo;
    logic hi_lt_end;
    logic lo_lt_end;
    logic start_lt_hi;
  } cmp_t;

endpackage

/* design/interval_set_table.sv */
// ---------------------------------------------------------------------------
// interval_set_table
// Table of disjoint half-open signed 64-bit intervals with add, remove,
// read and clear commands.
// ---------------------------------------------------------------------------
// The table holds up to MAX_INTERVALS disjoint intervals [lo, hi) in a
// single-port-write, single-port-read memory, with one valid flip-flop per
// slot. Add and remove walk every slot in order, one slot per clock, through
// one shared compare unit and then a finish state, with a second write state
// after it when a remove splits a stored interval (the two halves need two
// memory writes). A read passes through a read state, and clear or an empty
// interval (lo >= hi) goes straight to the done state. The input
// side is ready only while no command is in flight; the finished result sits
// in an output register, so a new command may be taken while the previous
// result still waits for its consumer. No clearing pass is needed after
// reset: only the valid bits are cleared, and a slot is never read as
// holding an interval until it has been written.
// ---------------------------------------------------------------------------
module interval_set_table #(
  parameter int MAX_INTERVALS = 64
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic signed [63:0] lo,
  input  logic signed [63:0] hi,
  input  logic [5:0]  slot,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        slot_valid,
  output logic signed [63:0] slot_lo,
  output logic signed [63:0] slot_hi,
  output logic [6:0]  interval_count,
  output logic        is_empty
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_WR2  = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;

  // Table state: valid bits and occupancy count.
  logic [MAX_INTERVALS-1:0] valid;
  logic [CW-1:0]            count;

  // Working interval and command of the item in flight.
  logic        op_add;
  logic [63:0] cur_lo;
  logic [63:0] cur_hi;

  // Scan pipeline: issue_idx addresses the memory, chk_idx is the slot whose
  // data arrives this cycle.
  logic [AW:0]   issue_idx;
  logic          issue_done;
  logic          chk_vld;
  logic [AW-1:0] chk_idx;

  // Lowest free slot seen so far, and the stored interval that strictly
  // contains a remove range (it gets split at the end of the scan).
  logic          found_free;
  logic [AW-1:0] free_idx;
  logic          contain;
  logic [AW-1:0] con_idx;
  ist_pkg::entry_t con_ent;

  // Result of the item in flight, then the output register.
  logic [1:0]  res_status;
  logic        res_valid;
  logic [63:0] res_lo;
  logic [63:0] res_hi;

  // Memory and compare unit connections.
  logic            we;
  logic [AW-1:0]   waddr;
  ist_pkg::entry_t wdata;
  logic [AW-1:0]   raddr;
  ist_pkg::entry_t rdata;
  ist_pkg::cmp_t   cmp;

  // Per-slot decisions of the scan.
  logic ent_v;
  logic add_merge;
  logic rem_ovl;
  logic rem_contain;
  logic slot_ok;
  logic [AW-1:0] slot_idx;
  logic in_accept;
  logic out_load;

  ist_mem #(
    .DEPTH (MAX_INTERVALS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ist_cmp u_cmp (
    .entry (rdata),
    .lo    (cur_lo),
    .hi    (cur_hi),
    .res   (cmp)
  );

  assign in_ready   = (state == S_IDLE);
  assign in_accept  = in_valid && in_ready;
  // The finished result moves into the output register once it is free or
  // being emptied in the same cycle.
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);
  assign issue_done = (issue_idx == (AW+1)'(MAX_INTERVALS));
  assign slot_ok    = (32'(slot) < MAX_INTERVALS);
  assign slot_idx   = AW'(slot);

  assign ent_v       = valid[chk_idx];
  // Add merges with anything that overlaps or touches the working interval.
  assign add_merge   = ent_v && !cmp.hi_lt_start && !cmp.end_lt_lo;
  // Remove acts on anything that truly overlaps the cut range.
  assign rem_ovl     = ent_v && cmp.lo_lt_end && cmp.start_lt_hi;
  assign rem_contain = rem_ovl && cmp.start_lt_lo && cmp.hi_lt_end;

  assign raddr = (state == S_IDLE) ? slot_idx : issue_idx[AW-1:0];

  // Memory writes: trims during a remove scan, the new or split entry at the
  // end of the scan, and the lower half of a split in the cycle after.
  always_comb begin
    we    = 1'b0;
    waddr = chk_idx;
    wdata = rdata;
    unique case (state)
      S_SCAN: begin
        if (chk_vld && !op_add && rem_ovl && !rem_contain) begin
          if (cmp.start_lt_lo) begin
            we    = 1'b1;
            wdata = '{lo: rdata.lo, hi: cur_lo};
          end else if (cmp.hi_lt_end) begin
            we    = 1'b1;
            wdata = '{lo: cur_hi, hi: rdata.hi};
          end
        end
      end
      S_FIN: begin
        waddr = free_idx;
        if (op_add) begin
          we    = found_free;
          wdata = '{lo: cur_lo, hi: cur_hi};
        end else begin
          we    = contain && found_free;
          wdata = '{lo: cur_hi, hi: con_ent.hi};
        end
      end
      S_WR2: begin
        we    = 1'b1;
        waddr = con_idx;
        wdata = '{lo: con_ent.lo, hi: cur_lo};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            op_add     <= (cmd == ist_pkg::CMD_ADD);
            cur_lo     <= lo;
            cur_hi     <= hi;
            res_status <= ist_pkg::ST_OK;
            res_valid  <= 1'b0;
            res_lo     <= '0;
            res_hi     <= '0;
            issue_idx  <= '0;
            chk_vld    <= 1'b0;
            found_free <= 1'b0;
            contain    <= 1'b0;
            unique case (cmd) inside
              ist_pkg::CMD_ADD, ist_pkg::CMD_REMOVE: begin
                if (lo < hi) begin
                  state <= S_SCAN;
                end else begin
                  res_status <= ist_pkg::ST_EMPTY;
                  state      <= S_DONE;
                end
              end
              ist_pkg::CMD_READ: begin
                res_valid <= slot_ok && valid[slot_idx];
                state     <= S_READ;
              end
              ist_pkg::CMD_CLEAR: begin
                valid <= '0;
                count <= '0;
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          chk_vld <= !issue_done;
          chk_idx <= issue_idx[AW-1:0];
          if (!issue_done) begin
            issue_idx <= issue_idx + (AW+1)'(1);
          end

          if (chk_vld) begin
            if (op_add) begin
              if (add_merge) begin
                if (cmp.start_lt_lo) begin
                  cur_lo <= rdata.lo;
                end
                if (cmp.hi_lt_end) begin
                  cur_hi <= rdata.hi;
                end
                valid[chk_idx] <= 1'b0;
                count          <= count - CW'(1);
              end
              // A slot freed by a merge counts as free for the union.
              if (!found_free && (!ent_v || add_merge)) begin
                found_free <= 1'b1;
                free_idx   <= chk_idx;
              end
            end else begin
              if (rem_contain) begin
                contain <= 1'b1;
                con_idx <= chk_idx;
                con_ent <= rdata;
              end else if (rem_ovl && !cmp.start_lt_lo && !cmp.hi_lt_end) begin
                valid[chk_idx] <= 1'b0;
                count          <= count - CW'(1);
              end
              if (!found_free && !ent_v) begin
                found_free <= 1'b1;
                free_idx   <= chk_idx;
              end
            end
          end else if (issue_done) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          state <= S_DONE;
          if (op_add) begin
            if (found_free) begin
              valid[free_idx] <= 1'b1;
              count           <= count + CW'(1);
            end else begin
              res_status <= ist_pkg::ST_FULL;
            end
          end else if (contain) begin
            if (found_free) begin
              valid[free_idx] <= 1'b1;
              count           <= count + CW'(1);
              state           <= S_WR2;
            end else begin
              res_status <= ist_pkg::ST_FULL;
            end
          end
        end

        S_WR2: begin
          state <= S_DONE;
        end

        S_READ: begin
          if (res_valid) begin
            res_lo <= rdata.lo;
            res_hi <= rdata.hi;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_load) begin
            status         <= res_status;
            slot_valid     <= res_valid;
            slot_lo        <= res_lo;
            slot_hi        <= res_hi;
            interval_count <= 7'(count);
            is_empty       <= (count == '0);
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/ist_cmp.sv */
// ---------------------------------------------------------------------------
// ist_cmp
// Shared compare unit: relates one stored entry to the working interval.
// ---------------------------------------------------------------------------
module ist_cmp (
  input  ist_pkg::entry_t entry,
  input  logic [63:0]     lo,
  input  logic [63:0]     hi,
  output ist_pkg::cmp_t   res
);

  assign res.hi_lt_start = $signed(hi) < $signed(entry.lo);
  assign res.end_lt_lo   = $signed(entry.hi) < $signed(lo);
  assign res.start_lt_lo = $signed(entry.lo) < $signed(lo);
  assign res.hi_lt_end   = $signed(hi) < $signed(entry.hi);
  assign res.lo_lt_end   = $signed(lo) < $signed(entry.hi);
  assign res.start_lt_hi = $signed(entry.lo) < $signed(hi);

endmodule

/* design/ist_mem.sv */
// ---------------------------------------------------------------------------
// ist_mem
// Interval storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ist_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ist_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output ist_pkg::entry_t rdata
);

  ist_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ist_checker.sv */
// ---------------------------------------------------------------------------
// ist_checker
// Port-level checks on the interval set table, bound to the top level.
// ---------------------------------------------------------------------------
`include "interval_set_table_defines.svh"

module ist_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        slot_valid,
  input logic signed [63:0] slot_lo,
  input logic signed [63:0] slot_hi,
  input logic [6:0]  interval_count,
  input logic        is_empty
);

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  // A stalled result beat holds its status.
  `IST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
  // Each accepted command closes the input side in the cycle after it is taken.
  `IST_ASSERT_NEXT(a_busy_after_accept, in_beat, !in_ready)
  // An empty table always reports a zero count.
  `IST_ASSERT_HOLD(a_empty_count, out_valid && is_empty, interval_count == 7'd0)
  // A slot that reads back valid holds a proper interval in a nonempty table.
  `IST_ASSERT_HOLD(a_read_proper, out_valid && slot_valid,
                   !is_empty && status == ist_pkg::ST_OK && slot_lo < slot_hi)
  // Nothing valid means the slot fields read as zero.
  `IST_ASSERT_HOLD(a_read_zero, out_valid && !slot_valid,
                   slot_lo == 64'sd0 && slot_hi == 64'sd0)

endmodule

bind interval_set_table ist_checker u_ist_checker (.*);

/* tb/tb_interval_set_table.sv */
// ---------------------------------------------------------------------------
// tb_interval_set_table
// Self-checking testbench for the interval set table: a behavioral copy of
// the table predicts every result beat, and directed, table-full,
// back-pressure and random tests run in turn against the block.
// ---------------------------------------------------------------------------
module tb_interval_set_table;

  localparam int TABLE_DEPTH = 64;
  // The slowest legal run is about 1500 beats plus long gaps on both sides.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // One expected result beat, field for field as the block's output ports.
  typedef struct packed {
    logic [1:0]  status;
    logic        slot_valid;
    logic [63:0] slot_lo;
    logic [63:0] slot_hi;
    logic [6:0]  interval_count;
    logic        is_empty;
  } table_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         cmd;
  logic signed [63:0] lo;
  logic signed [63:0] hi;
  logic [5:0]         slot;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic               slot_valid;
  logic signed [63:0] slot_lo;
  logic signed [63:0] slot_hi;
  logic [6:0]         interval_count;
  logic               is_empty;

  interval_set_table #(
    .MAX_INTERVALS(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .lo(lo),
    .hi(hi),
    .slot(slot),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .slot_valid(slot_valid),
    .slot_lo(slot_lo),
    .slot_hi(slot_hi),
    .interval_count(interval_count),
    .is_empty(is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Shadow copy of the table. It is updated once per accepted input beat, in
  // acceptance order, so the queue of awaited results lines up with the
  // order in which the block hands its results out.
  // -------------------------------------------------------------------------
  bit                 tbl_used    [TABLE_DEPTH];
  logic signed [63:0] tbl_lo      [TABLE_DEPTH];
  logic signed [63:0] tbl_hi      [TABLE_DEPTH];
  // A slot counts as written once an interval has ever been stored in it.
  // Reads are only aimed at such slots, because the memory behind a slot is
  // undefined until its first write.
  bit                 slot_written[TABLE_DEPTH];
  int                 tbl_count;

  table_result_t awaited_results[$];
  int            fail_count = 0;

  // Knobs shared by the stimulus and the consumer process.
  bit sender_gaps_on   = 1'b1;
  bit receiver_gaps_on = 1'b1;
  int hold_request     = 0;

  function automatic int first_free_slot();
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (!tbl_used[i])
        return i;
    return -1;
  endfunction

  function automatic void store_interval(int idx, logic signed [63:0] a,
                                         logic signed [63:0] b);
    tbl_used[idx]     = 1'b1;
    tbl_lo[idx]       = a;
    tbl_hi[idx]       = b;
    slot_written[idx] = 1'b1;
    tbl_count++;
  endfunction

  // Add: every stored interval that overlaps or merely touches [a, b) is
  // folded into it and freed, then the union lands in the lowest free slot.
  // A slot is only missing when nothing was merged, so a full table is left
  // exactly as it was.
  function automatic logic [1:0] unite_interval(logic signed [63:0] a,
                                                logic signed [63:0] b);
    int dst;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_used[i] && !(b < tbl_lo[i] || tbl_hi[i] < a)) begin
        if (tbl_lo[i] < a)
          a = tbl_lo[i];
        if (b < tbl_hi[i])
          b = tbl_hi[i];
        tbl_used[i] = 1'b0;
        tbl_count--;
      end
    end
    dst = first_free_slot();
    if (dst < 0)
      return ist_pkg::ST_FULL;
    store_interval(dst, a, b);
    return ist_pkg::ST_OK;
  endfunction

  // Remove: a stored interval that strictly contains [a, b) is split and its
  // upper piece goes to the lowest free slot. Since the set is disjoint, no
  // other interval can be touched in that case. Otherwise partial overlaps
  // are trimmed and fully covered intervals are dropped.
  function automatic logic [1:0] cut_interval(logic signed [63:0] a,
                                              logic signed [63:0] b);
    int dst;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_used[i] && tbl_lo[i] < a && b < tbl_hi[i]) begin
        dst = first_free_slot();
        if (dst < 0)
          return ist_pkg::ST_FULL;
        store_interval(dst, b, tbl_hi[i]);
        tbl_hi[i] = a;
        return ist_pkg::ST_OK;
      end
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_used[i] && a < tbl_hi[i] && tbl_lo[i] < b) begin
        if (tbl_lo[i] < a) begin
          tbl_hi[i] = a;
        end else if (b < tbl_hi[i]) begin
          tbl_lo[i] = b;
        end else begin
          tbl_used[i] = 1'b0;
          tbl_count--;
        end
      end
    end
    return ist_pkg::ST_OK;
  endfunction

  // Applies one input beat to the shadow table and returns the result beat
  // the block must produce for it. Non-read commands and reads of an empty
  // slot report the slot fields as zero.
  function automatic table_result_t interval_set_step(logic [1:0] c,
                                                      logic signed [63:0] a,
                                                      logic signed [63:0] b,
                                                      logic [5:0] s);
    table_result_t r;
    r = '0;
    case (c) inside
      ist_pkg::CMD_ADD, ist_pkg::CMD_REMOVE: begin
        // An empty or reversed interval leaves the table untouched.
        if (!(a < b))
          r.status = ist_pkg::ST_EMPTY;
        else if (c == ist_pkg::CMD_ADD)
          r.status = unite_interval(a, b);
        else
          r.status = cut_interval(a, b);
      end
      ist_pkg::CMD_READ: begin
        if (tbl_used[s]) begin
          r.slot_valid = 1'b1;
          r.slot_lo    = tbl_lo[s];
          r.slot_hi    = tbl_hi[s];
        end
      end
      default: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          tbl_used[i] = 1'b0;
        tbl_count = 0;
      end
    endcase
    r.interval_count = 7'(tbl_count);
    r.is_empty       = (tbl_count == 0);
    return r;
  endfunction

  // Idle length for either side: mostly none, often a few cycles, and now
  // and then a long pause.
  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Random slot among those that are live (want_live) or merely written.
  // Returns -1 when there is none.
  function automatic int pick_slot(bit want_live);
    int candidates[$];
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (want_live ? tbl_used[i] : slot_written[i])
        candidates.push_back(i);
    if (candidates.size() == 0)
      return -1;
    return candidates[$urandom_range(0, candidates.size() - 1)];
  endfunction

  // -------------------------------------------------------------------------
  // Input side. Called right after a rising edge. Valid is raised with the
  // payload and held, unchanged, until the beat is taken; the expectation is
  // queued at the edge that accepts it. Valid is only lowered when a gap
  // follows, so it never gets two assignments in one time step.
  // -------------------------------------------------------------------------
  task automatic send_beat(logic [1:0] c, logic signed [63:0] a,
                           logic signed [63:0] b, logic [5:0] s);
    int gap;
    gap = pick_gap(sender_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    lo       <= a;
    hi       <= b;
    slot     <= s;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(interval_set_step(c, a, b, s));
  endtask

  // -------------------------------------------------------------------------
  // Output side. Ready is redrawn every cycle from the stall length picked
  // by pick_gap. A hold request from a test overrides that and keeps ready
  // low for the requested number of cycles, counted here.
  // -------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0) begin
        stall = pick_gap(receiver_gaps_on);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // Every result beat is matched against the oldest awaited result.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat arrived with no result awaited");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", want.status, status);
        compare_field("slot_valid", want.slot_valid, slot_valid);
        compare_field("slot_lo", want.slot_lo, slot_lo);
        compare_field("slot_hi", want.slot_hi, slot_hi);
        compare_field("interval_count", want.interval_count, interval_count);
        compare_field("is_empty", want.is_empty, is_empty);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Extremes of the 64-bit range, a split of the widest interval and its
  // repair by a touching add, empty and reversed intervals, merging of
  // neighbors, trims at either end, a remove that hits nothing, and clear.
  task automatic test_directed_cases();
    send_beat(ist_pkg::CMD_ADD, S64_MIN, S64_MAX, 6'd63);
    send_beat(ist_pkg::CMD_READ, S64_MAX, S64_MIN, 6'd0);
    send_beat(ist_pkg::CMD_REMOVE, -64'sd5, 64'sd7, 6'd0);
    send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'd0);
    send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'd1);
    send_beat(ist_pkg::CMD_ADD, -64'sd5, 64'sd7, 6'd42);
    send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'd0);
    // Slot 1 was freed by the merge, so it must read back as empty.
    send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'd1);
    send_beat(ist_pkg::CMD_ADD, 64'sd5, 64'sd5, 6'd0);
    send_beat(ist_pkg::CMD_REMOVE, 64'sd9, 64'sd3, 6'd0);
    send_beat(ist_pkg::CMD_ADD, S64_MAX, S64_MIN, 6'd0);
    send_beat(ist_pkg::CMD_REMOVE, S64_MIN, S64_MAX, 6'd21);
    send_beat(ist_pkg::CMD_ADD, 64'sd10, 64'sd20, 6'd0);
    send_beat(ist_pkg::CMD_ADD, 64'sd30, 64'sd40, 6'd0);
    send_beat(ist_pkg::CMD_ADD, 64'sd20, 64'sd30, 6'd0);
    send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'd0);
    send_beat(ist_pkg::CMD_REMOVE, 64'sd5, 64'sd15, 6'd0);
    send_beat(ist_pkg::CMD_REMOVE, 64'sd35, 64'sd50, 6'd0);
    send_beat(ist_pkg::CMD_REMOVE, 64'sd100, 64'sd200, 6'd0);
    send_beat(ist_pkg::CMD_ADD, -64'sd1, 64'sd0, 6'd0);
    send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'd1);
    send_beat(ist_pkg::CMD_CLEAR, S64_MIN, S64_MAX, 6'd63);
    send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'd0);
  endtask

  // Fills all slots, then checks that both an add with nowhere to go and a
  // split with nowhere to go are dropped, reads every slot, and frees space
  // again with trims, a merge and a sweeping remove.
  task automatic test_full_table();
    logic signed [63:0] base;
    base = $signed({$urandom, $urandom}) >>> 2;
    send_beat(ist_pkg::CMD_CLEAR, 64'sd0, 64'sd0, 6'($urandom_range(0, 63)));
    // The stride of 37 is coprime to 64, so this visits every spot once,
    // out of numeric order.
    for (int k = 0; k < TABLE_DEPTH; k++)
      send_beat(ist_pkg::CMD_ADD, base + 64'(10 * ((k * 37) % 64)),
                base + 64'(10 * ((k * 37) % 64) + 5), 6'($urandom_range(0, 63)));
    send_beat(ist_pkg::CMD_ADD, base + 64'sd1000, base + 64'sd1002, 6'd0);
    send_beat(ist_pkg::CMD_REMOVE, base + 64'sd12, base + 64'sd13, 6'd0);
    send_beat(ist_pkg::CMD_ADD, base + 64'sd5, base + 64'sd5, 6'd0);
    for (int s = 0; s < TABLE_DEPTH; s++)
      send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'(s));
    send_beat(ist_pkg::CMD_REMOVE, base + 64'sd20, base + 64'sd23, 6'd0);
    send_beat(ist_pkg::CMD_ADD, base + 64'sd5, base + 64'sd10, 6'd0);
    send_beat(ist_pkg::CMD_REMOVE, base + 64'sd12, base + 64'sd13, 6'd0);
    send_beat(ist_pkg::CMD_REMOVE, base + 64'sd1, base + 64'sd2, 6'd0);
    send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'd63);
    send_beat(ist_pkg::CMD_REMOVE, base - 64'sd100, base + 64'sd10000, 6'd0);
    send_beat(ist_pkg::CMD_READ, 64'sd0, 64'sd0, 6'd63);
  endtask

  // The consumer stops for a long stretch while beats keep coming back to
  // back: one result parks in the output register, one command is in flight,
  // and the input then has to stall until the consumer returns.
  task automatic test_backpressure();
    logic signed [63:0] a;
    in_valid <= 1'b0;
    sender_gaps_on = 1'b0;
    hold_request = 400;
    repeat (2) @(posedge clk);
    for (int n = 0; n < 12; n++) begin
      a = 64'sd5000 + 64'($urandom_range(0, 300));
      send_beat((n % 3 == 2) ? ist_pkg::CMD_REMOVE : ist_pkg::CMD_ADD, a,
                a + 64'($urandom_range(1, 40)), 6'($urandom_range(0, 63)));
    end
    sender_gaps_on = 1'b1;
  endtask

  // Random traffic in phases. Each phase picks a base point (the extremes
  // of the range among them), a window and an interval width: narrow
  // windows give heavy merging and splitting, wide ones fill the table
  // toward overflow. Gaps on either side switch on and off per phase.
  task automatic test_random_traffic();
    int                 window;
    int                 span_max;
    int                 roll;
    int                 pick;
    logic [1:0]         c;
    logic signed [63:0] base;
    logic signed [63:0] a;
    logic signed [63:0] b;
    for (int n = 0; n < 1350; n++) begin
      if (n % 150 == 0) begin
        sender_gaps_on   = ($urandom_range(0, 3) != 0);
        receiver_gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1) == 0) begin
          window   = 200;
          span_max = 30;
        end else begin
          window   = 3000;
          span_max = 12;
        end
        case ($urandom_range(0, 3))
          0: base = S64_MIN;
          1: base = S64_MAX - 64'sd4000;
          2: base = -64'sd1500;
          default: base = {$urandom, $urandom};
        endcase
      end
      roll = $urandom_range(0, 99);
      c    = ist_pkg::CMD_ADD;
      a    = base + 64'($urandom_range(0, window));
      b    = a + 64'($urandom_range(0, span_max));
      if (roll < 4) begin
        // Raw 64-bit endpoints: mostly far-flung, about half reversed.
        c = ($urandom_range(0, 1) == 0) ? ist_pkg::CMD_ADD : ist_pkg::CMD_REMOVE;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
      end else if (roll < 44) begin
        if ($urandom_range(0, 29) == 0)
          b = a - 64'($urandom_range(0, 5));
      end else if (roll < 74) begin
        c    = ist_pkg::CMD_REMOVE;
        pick = pick_slot(1'b1);
        // Half the removes are aimed at a live interval so that splits and
        // trims happen often.
        if (pick >= 0 && $urandom_range(0, 1) == 0) begin
          a = tbl_lo[pick] + 64'($urandom_range(0, 6)) - 64'sd2;
          b = a + 64'($urandom_range(1, 2 * span_max));
        end
      end else if (roll < 97) begin
        pick = pick_slot(1'b0);
        if (pick >= 0) begin
          c = ist_pkg::CMD_READ;
          send_beat(c, a, b, 6'(pick));
          continue;
        end
      end else begin
        c = ist_pkg::CMD_CLEAR;
      end
      send_beat(c, a, b, 6'($urandom_range(0, 63)));
    end
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    cmd      <= ist_pkg::CMD_READ;
    lo       <= '0;
    hi       <= '0;
    slot     <= '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_used[i]     = 1'b0;
      tbl_lo[i]       = '0;
      tbl_hi[i]       = '0;
      slot_written[i] = 1'b0;
    end
    tbl_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_table();
    test_backpressure();
    test_random_traffic();

    // The last beat was taken at this edge; drop valid so it is not taken
    // twice, drain what is still owed, then idle to catch strays.
    in_valid <= 1'b0;
    while (awaited_results.size() != 0)
      @(posedge clk);
    repeat (2 * TABLE_DEPTH) @(posedge clk);

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
